// ----- sv/hdc_pkg.sv -----
// Package for the hashed direct-mapped entry cache.
// Holds the table size, hash constants and the item, result and slot types.
// No dependencies.
`timescale 1ns / 1ps

package hdc_pkg;

  // Table geometry. The index is the hash masked with ENTRIES-1.
  localparam int unsigned ENTRIES = 512;
  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] IDX_MASK = IDX_W'(ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

  // Finalizer multipliers of the 32-bit mix.
  localparam logic [31:0] MIX_C1 = 32'h85eb_ca6b;
  localparam logic [31:0] MIX_C2 = 32'hc2b2_ae35;

  // Command codes.
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // One input item.
  typedef struct packed {
    logic        command;
    logic [31:0] key;
    logic [15:0] entry_kind;
    logic [15:0] entry_flags;
    logic [31:0] target_type;
    logic [31:0] property_code;
    logic [63:0] data_low;
    logic [63:0] data_high;
  } item_t;

  // One result item.
  typedef struct packed {
    logic        hit;
    logic [15:0] found_kind;
    logic [15:0] found_flags;
    logic [31:0] found_target_type;
    logic [31:0] found_property;
    logic [63:0] found_data_low;
    logic [63:0] found_data_high;
    logic [31:0] stamp;
    logic [63:0] hits_total;
    logic [63:0] misses_total;
  } result_t;

  // One stored slot.
  typedef struct packed {
    logic [31:0] key;
    logic [15:0] kind;
    logic [15:0] flags;
    logic [31:0] target_type;
    logic [31:0] property_code;
    logic [63:0] data_low;
    logic [63:0] data_high;
  } slot_t;

  // Contents of an empty slot: all-ones key, zero payload.
  localparam slot_t SLOT_EMPTY = '{
    key:           32'hffff_ffff,
    kind:          16'h0,
    flags:         16'h0,
    target_type:   32'h0,
    property_code: 32'h0,
    data_low:      64'h0,
    data_high:     64'h0
  };

endpackage

// ----- sv/hdc_hash.sv -----
// Two-stage pipelined 32-bit finalizer mix that produces the slot index.
// Depends on hdc_pkg for the multipliers and index width.
`timescale 1ns / 1ps

module hdc_hash
  import hdc_pkg::*;
(
  input  logic             clk,
  input  logic [31:0]      key_in,
  output logic [IDX_W-1:0] index_out
);

  logic [31:0] fold0;
  logic [31:0] fold1;
  logic [31:0] fold2;
  logic [31:0] mul1_r;
  logic [31:0] mul2_r;

  // First fold and multiply, registered.
  assign fold0 = key_in ^ (key_in >> 16);

  always_ff @(posedge clk) begin
    mul1_r <= fold0 * MIX_C1;
  end

  // Second fold and multiply, registered.
  assign fold1 = mul1_r ^ (mul1_r >> 13);

  always_ff @(posedge clk) begin
    mul2_r <= fold1 * MIX_C2;
  end

  // Last fold, then mask down to the table.
  assign fold2     = mul2_r ^ (mul2_r >> 16);
  assign index_out = fold2[IDX_W-1:0] & IDX_MASK;

endmodule

// ----- sv/hdc_slot_ram.sv -----
// Slot memory: one write port and one read port with registered read data.
// Depends on hdc_pkg for the slot type and table size.
`timescale 1ns / 1ps

module hdc_slot_ram
  import hdc_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_t            wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t mem [ENTRIES];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/hashed_direct_mapped_entry_cache.sv -----
// Top level of the hashed direct-mapped entry cache: control, counters, result.
// Depends on hdc_pkg, hdc_hash and hdc_slot_ram.
`timescale 1ns / 1ps
//
//  Channel   Ports                       Direction  Transfer
//  input     start, busy, in_item        in         start high while busy low
//  result    out_valid, out_result       out        one-cycle strobe, no stall
//
//  Each item passes from idle through S_MIX1 and S_MIX2, the two registered
//  multiplies of the index hash, S_ACCESS for the memory access and
//  S_RESOLVE to resolve and register the result, then back to idle, which
//  shows the result and takes the next item.
//  The result on out_result is marked by out_valid for one cycle, in the cycle in which busy
//  drops, so the next item may be accepted while it is shown.
//  After reset a clearing pass writes every slot empty, with busy high.
//  The receiver cannot stall the result strobe.

module hashed_direct_mapped_entry_cache
  import hdc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  item_t   in_item,
  output logic    out_valid,
  output result_t out_result
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_ACCESS,
    S_RESOLVE
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] clr_idx_r;
  item_t            item_r;
  logic [31:0]      clock_r;
  logic [63:0]      hits_r;
  logic [63:0]      misses_r;
  logic             out_valid_r;
  result_t          out_r;

  logic [IDX_W-1:0] slot_idx;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  slot_t            ram_wdata;
  logic             ram_re;
  slot_t            ram_rdata;
  slot_t            insert_slot;
  logic             accept;
  logic             key_match;
  logic [31:0]      clock_inc;
  result_t          res_nxt;
  logic [31:0]      clock_nxt;
  logic [63:0]      hits_nxt;
  logic [63:0]      misses_nxt;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // Index hash runs off the captured item.
  hdc_hash u_hash (
    .clk       (clk),
    .key_in    (item_r.key),
    .index_out (slot_idx)
  );

  // Slot contents written by an insert.
  always_comb begin
    insert_slot.key           = item_r.key;
    insert_slot.kind          = item_r.entry_kind;
    insert_slot.flags         = item_r.entry_flags;
    insert_slot.target_type   = item_r.target_type;
    insert_slot.property_code = item_r.property_code;
    insert_slot.data_low      = item_r.data_low;
    insert_slot.data_high     = item_r.data_high;
  end

  // Memory port control: clearing sweep, insert write or lookup read.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_idx;
    ram_wdata = insert_slot;
    ram_re    = 1'b0;
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx_r;
      ram_wdata = SLOT_EMPTY;
    end else if (state_r == S_ACCESS) begin
      ram_we = (item_r.command == CMD_INSERT);
      ram_re = (item_r.command == CMD_LOOKUP);
    end
  end

  hdc_slot_ram u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (slot_idx),
    .rd_data (ram_rdata)
  );

  assign key_match = (ram_rdata.key == item_r.key);
  assign clock_inc = clock_r + 32'd1;

  // Result and counter updates for the item being resolved.
  always_comb begin
    res_nxt    = '0;
    clock_nxt  = clock_r;
    hits_nxt   = hits_r;
    misses_nxt = misses_r;
    if (item_r.command == CMD_INSERT) begin
      clock_nxt     = clock_inc;
      res_nxt.stamp = clock_inc;
    end else if (key_match) begin
      clock_nxt                 = clock_inc;
      hits_nxt                  = hits_r + 64'd1;
      res_nxt.hit               = 1'b1;
      res_nxt.found_kind        = ram_rdata.kind;
      res_nxt.found_flags       = ram_rdata.flags;
      res_nxt.found_target_type = ram_rdata.target_type;
      res_nxt.found_property    = ram_rdata.property_code;
      res_nxt.found_data_low    = ram_rdata.data_low;
      res_nxt.found_data_high   = ram_rdata.data_high;
      res_nxt.stamp             = clock_inc;
    end else begin
      misses_nxt = misses_r + 64'd1;
    end
    res_nxt.hits_total   = hits_nxt;
    res_nxt.misses_total = misses_nxt;
  end

  // Sequencer, counters and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_idx_r   <= '0;
      clock_r     <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_RESOLVE);
      unique case (state_r)
        S_CLEAR: begin
          clr_idx_r <= clr_idx_r + 1'b1;
          if (clr_idx_r == IDX_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            item_r  <= in_item;
            state_r <= S_MIX1;
          end
        end
        S_MIX1: begin
          state_r <= S_MIX2;
        end
        S_MIX2: begin
          state_r <= S_ACCESS;
        end
        S_ACCESS: begin
          state_r <= S_RESOLVE;
        end
        S_RESOLVE: begin
          out_r    <= res_nxt;
          clock_r  <= clock_nxt;
          hits_r   <= hits_nxt;
          misses_r <= misses_nxt;
          state_r  <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_r;

  // An accepted item is always followed by its result strobe.
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result did not follow an accepted item");

  // The result strobe lasts one cycle.
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // Counters move only while an item is being resolved.
  a_counters_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RESOLVE) |=> ($stable(hits_r) && $stable(misses_r) && $stable(clock_r)))
    else $error("counters changed outside of resolve");

  // A shown stamp is the current access clock, or zero on a miss.
  a_stamp_current: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result.stamp == clock_r) ||
                   ((out_result.stamp == 32'd0) && !out_result.hit)))
    else $error("result stamp does not match the access clock");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the hashed direct-mapped entry cache.
// Keeps its own copy of the table and counters and checks each result item.
// Depends on hdc_pkg and hashed_direct_mapped_entry_cache.
`timescale 1ns / 1ps

module testbench
  import hdc_pkg::*;
();

  localparam int CYCLE_LIMIT = 100000;
  localparam int MAX_REPORTS = 40;
  localparam int POOL_SIZE = 24;

  logic    clk = 1'b0;
  logic    rst_n;
  logic    start;
  logic    busy;
  item_t   in_item;
  logic    out_valid;
  result_t out_result;

  // Expected table contents and counters.
  slot_t       model_slot [ENTRIES];
  logic [31:0] model_clock;
  logic [63:0] model_hits;
  logic [63:0] model_misses;

  // Results still owed by the block, oldest first.
  result_t pending_results [$];
  int      mismatches = 0;
  int      cycle_count = 0;

  // Keys reused by the random traffic so that lookups find something.
  logic [31:0] key_pool [POOL_SIZE];

  hashed_direct_mapped_entry_cache uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  always #5 clk = ~clk;

  // Run limit; the clearing pass after reset is small against it.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Murmur3 32-bit finalizer.
  function automatic logic [31:0] fmix32(input logic [31:0] v);
    v = v ^ (v >> 16);
    v = v * MIX_C1;
    v = v ^ (v >> 13);
    v = v * MIX_C2;
    v = v ^ (v >> 16);
    return v;
  endfunction

  function automatic logic [IDX_W-1:0] slot_index(input logic [31:0] key);
    logic [31:0] h;
    h = fmix32(key);
    return h[IDX_W-1:0] & IDX_MASK;
  endfunction

  // A different key that lands in the same slot as the given one.
  function automatic logic [31:0] slot_twin(input logic [31:0] key);
    logic [31:0] k;
    do begin
      k = $urandom;
    end while (k == key || slot_index(k) != slot_index(key));
    return k;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < ENTRIES; i++) begin
      model_slot[i] = SLOT_EMPTY;
    end
    model_clock = '0;
    model_hits = '0;
    model_misses = '0;
  endfunction

  // Applies one item to the expected table and returns the result it causes.
  function automatic result_t cache_access(input item_t it);
    result_t          r;
    logic [IDX_W-1:0] idx;
    r = '0;
    idx = slot_index(it.key);
    if (it.command == CMD_INSERT) begin
      model_clock = model_clock + 32'd1;
      model_slot[idx].key = it.key;
      model_slot[idx].kind = it.entry_kind;
      model_slot[idx].flags = it.entry_flags;
      model_slot[idx].target_type = it.target_type;
      model_slot[idx].property_code = it.property_code;
      model_slot[idx].data_low = it.data_low;
      model_slot[idx].data_high = it.data_high;
      r.stamp = model_clock;
    end else if (model_slot[idx].key == it.key) begin
      model_clock = model_clock + 32'd1;
      model_hits = model_hits + 64'd1;
      r.hit = 1'b1;
      r.found_kind = model_slot[idx].kind;
      r.found_flags = model_slot[idx].flags;
      r.found_target_type = model_slot[idx].target_type;
      r.found_property = model_slot[idx].property_code;
      r.found_data_low = model_slot[idx].data_low;
      r.found_data_high = model_slot[idx].data_high;
      r.stamp = model_clock;
    end else begin
      model_misses = model_misses + 64'd1;
    end
    r.hits_total = model_hits;
    r.misses_total = model_misses;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
      end
    end
  endtask

  // Result checker and acceptance monitor. The result is matched before a
  // new expectation is queued, since both can happen at one edge.
  always @(posedge clk) begin
    result_t exp_r;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t ns: result with no item pending, expected none, got %h",
                   $time, out_result);
        end
      end else begin
        exp_r = pending_results.pop_front();
        check_field("hit", 64'(exp_r.hit), 64'(out_result.hit));
        check_field("found_kind", 64'(exp_r.found_kind), 64'(out_result.found_kind));
        check_field("found_flags", 64'(exp_r.found_flags), 64'(out_result.found_flags));
        check_field("found_target_type", 64'(exp_r.found_target_type),
                    64'(out_result.found_target_type));
        check_field("found_property", 64'(exp_r.found_property),
                    64'(out_result.found_property));
        check_field("found_data_low", exp_r.found_data_low, out_result.found_data_low);
        check_field("found_data_high", exp_r.found_data_high, out_result.found_data_high);
        check_field("stamp", 64'(exp_r.stamp), 64'(out_result.stamp));
        check_field("hits_total", exp_r.hits_total, out_result.hits_total);
        check_field("misses_total", exp_r.misses_total, out_result.misses_total);
      end
    end
    if (rst_n === 1'b1 && start === 1'b1 && busy === 1'b0) begin
      pending_results.push_back(cache_access(in_item));
    end
  end

  // Presents one item and returns at the edge that accepts it. Start stays
  // high so that a following item goes out without a gap.
  task automatic issue(input item_t it);
    @(negedge clk);
    start <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic pause(input int n);
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  function automatic item_t make_item(input logic cmd, input logic [31:0] key);
    item_t it;
    it.command = cmd;
    it.key = key;
    it.entry_kind = 16'($urandom);
    it.entry_flags = 16'($urandom);
    it.target_type = $urandom;
    it.property_code = $urandom;
    it.data_low = {$urandom, $urandom};
    it.data_high = {$urandom, $urandom};
    return it;
  endfunction

  function automatic item_t filled_item(input logic [31:0] key, input logic fill);
    item_t it;
    it = make_item(CMD_INSERT, key);
    it.entry_kind = {16{fill}};
    it.entry_flags = {16{fill}};
    it.target_type = {32{fill}};
    it.property_code = {32{fill}};
    it.data_low = {64{fill}};
    it.data_high = {64{fill}};
    return it;
  endfunction

  // Lookups on a fresh table: two plain misses, and the all-ones key, which
  // matches a slot that was never written and returns a zero payload.
  task automatic test_empty_table();
    issue(make_item(CMD_LOOKUP, 32'h0000_0000));
    issue(make_item(CMD_LOOKUP, 32'hffff_ffff));
    issue(make_item(CMD_LOOKUP, 32'h8000_0001));
  endtask

  // Inserts with all-zero and all-ones payloads, then repeated hits on the
  // same slot, each of which takes a fresh stamp.
  task automatic test_insert_extremes();
    logic [31:0] k;
    k = $urandom;
    issue(filled_item(32'h0000_0000, 1'b0));
    issue(make_item(CMD_LOOKUP, 32'h0000_0000));
    issue(filled_item(k, 1'b1));
    issue(make_item(CMD_LOOKUP, k));
    issue(make_item(CMD_LOOKUP, k));
    issue(make_item(CMD_LOOKUP, k));
    issue(filled_item(32'hffff_ffff, 1'b1));
    issue(make_item(CMD_LOOKUP, 32'hffff_ffff));
  endtask

  // Two keys sharing a slot: an insert evicts whatever the slot held.
  task automatic test_slot_conflicts();
    logic [31:0] a;
    logic [31:0] b;
    a = $urandom;
    b = slot_twin(a);
    issue(make_item(CMD_INSERT, a));
    issue(make_item(CMD_LOOKUP, b));
    issue(make_item(CMD_INSERT, b));
    issue(make_item(CMD_LOOKUP, a));
    issue(make_item(CMD_LOOKUP, b));
    issue(make_item(CMD_INSERT, a));
    issue(make_item(CMD_LOOKUP, a));
    // An all-ones lookup into a slot now owned by another key misses.
    issue(make_item(CMD_INSERT, slot_twin(32'hffff_ffff)));
    issue(make_item(CMD_LOOKUP, 32'hffff_ffff));
  endtask

  function automatic void fill_pool();
    for (int i = 0; i < 12; i++) key_pool[i] = $urandom;
    for (int i = 12; i < 22; i++) key_pool[i] = slot_twin(key_pool[i - 12]);
    key_pool[22] = 32'hffff_ffff;
    key_pool[23] = 32'h0000_0000;
  endfunction

  // Mostly lookups of recently used keys, with inserts that keep evicting
  // their slot twins, plus some cold and all-ones lookups.
  function automatic item_t random_item();
    int          pick;
    int          slot_sel;
    logic [31:0] k;
    if ($urandom_range(49) == 0) begin
      slot_sel = $urandom_range(POOL_SIZE - 1);
      key_pool[slot_sel] = $urandom_range(1) ? $urandom
                         : slot_twin(key_pool[$urandom_range(POOL_SIZE - 1)]);
    end
    pick = $urandom_range(99);
    k = key_pool[$urandom_range(POOL_SIZE - 1)];
    if (pick < 35) begin
      return make_item(CMD_INSERT, ($urandom_range(9) < 8) ? k : $urandom);
    end else if (pick < 85) begin
      return make_item(CMD_LOOKUP, k);
    end else if (pick < 95) begin
      return make_item(CMD_LOOKUP, $urandom);
    end
    return make_item(CMD_LOOKUP, 32'hffff_ffff);
  endfunction

  // Random traffic with bursts of idle cycles between items.
  task automatic test_random_traffic(input int count);
    bit idle_on;
    idle_on = 1'b1;
    fill_pool();
    repeat (count) begin
      if ($urandom_range(29) == 0) idle_on = !idle_on;
      if (idle_on && $urandom_range(99) < 40) pause($urandom_range(1, 13));
      issue(random_item());
    end
  endtask

  // Random traffic at full rate to close the run.
  task automatic test_streaming(input int count);
    repeat (count) issue(random_item());
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    clear_table();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_insert_extremes();
    test_slot_conflicts();
    test_random_traffic(450);
    test_streaming(150);
    pause(1);

    // Drain, then give stray results time to show up.
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
